>>> hw/rtl/dbdf_pkg.sv
// ----------------------------------------------------------------------------
// dbdf_pkg
// Shared constants and types for the detection box decode and filter block.
// ----------------------------------------------------------------------------
package dbdf_pkg;

	localparam int VALUE_W       = 32;
	localparam int FRAC_BITS     = 16;
	localparam int CORNER_W      = 30;
	localparam int SCORE_W       = 17;
	localparam int CLASS_ID_W    = 7;
	localparam int ROW_W         = 16;
	localparam int THRESH_W      = 17;
	localparam int CLASS_COUNT_W = 8;
	localparam int SCALE_W       = 21;
	localparam int SIZE_W        = 14;
	localparam int CFG_DATA_W    = 30;
	localparam int CFG_INDEX_W   = 3;

	// element order at the head of each row
	localparam int FIELD_CX    = 0;
	localparam int FIELD_CY    = 1;
	localparam int FIELD_W     = 2;
	localparam int FIELD_H     = 3;
	localparam int FIELD_OBJ   = 4;
	localparam int BOX_FIELDS  = 5;

	localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_LABEL_MODE  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_CLASS_COUNT = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_PAD_X       = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_PAD_Y       = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_INV_SCALE   = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMG_WIDTH   = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMG_HEIGHT  = 3'd7;

	// corner order within a box
	localparam int CORNERS  = 4;
	localparam int C_LEFT   = 0;
	localparam int C_TOP    = 1;
	localparam int C_RIGHT  = 2;
	localparam int C_BOTTOM = 3;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [CORNER_W-1:0]       corner_t;

endpackage

>>> hw/rtl/detection_box_decode_filter.sv
// ----------------------------------------------------------------------------
// detection_box_decode_filter
// Decodes detector output rows into clamped image-space boxes with scores.
// ----------------------------------------------------------------------------
// One row element is taken per beat, one beat per cycle sustained: centre x,
// centre y, width, height, objectness, then class_count class scores (at
// least one, at most MAX_CLASSES). Each class score that yields a box passes
// through registers for the row state, the 32 x 32 confidence multiplier,
// the split corner multipliers, and the sum, shift and clamp into the output
// register. The stages hold independently, so a stall on the result side
// fills bubbles before the input is held. There is no start-up sweep; the
// block takes beats right after reset. Registers must be written only while
// no result is outstanding; the block itself does not enforce it.
module detection_box_decode_filter #(
	parameter int MAX_CLASSES = 128
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [dbdf_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [dbdf_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 item_valid,
	output logic                                 item_ready,
	input  logic signed [dbdf_pkg::VALUE_W-1:0]  value,
	output logic                                 box_valid,
	input  logic                                 box_ready,
	output logic [dbdf_pkg::CORNER_W-1:0]        left,
	output logic [dbdf_pkg::CORNER_W-1:0]        top,
	output logic [dbdf_pkg::CORNER_W-1:0]        right,
	output logic [dbdf_pkg::CORNER_W-1:0]        bottom,
	output logic [dbdf_pkg::SCORE_W-1:0]         score,
	output logic [dbdf_pkg::CLASS_ID_W-1:0]      class_id,
	output logic [dbdf_pkg::ROW_W-1:0]           row_index
);
	import dbdf_pkg::*;

	localparam int POS_W = $clog2(MAX_CLASSES + BOX_FIELDS);
	localparam int IDX_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
	localparam int CNT_W = $clog2(MAX_CLASSES + 1);
	localparam int CMP_W = (CNT_W > CLASS_COUNT_W) ? CNT_W : CLASS_COUNT_W;
	localparam int SPAN_W = VALUE_W + 2;
	localparam int LO_W = FRAC_BITS + 1;
	localparam int HI_W = SPAN_W - LO_W;
	localparam int PL_W = LO_W + SCALE_W;
	localparam int PH_W = HI_W + SCALE_W + 1;
	localparam int SUM_W = PH_W + LO_W;
	localparam int SHF_W = SUM_W - FRAC_BITS;
	localparam int PROD_W = 2 * VALUE_W;
	localparam int CONF_W = PROD_W - FRAC_BITS;

	// configuration
	logic                     multi_q;
	logic [THRESH_W-1:0]      thresh_q;
	logic [CLASS_COUNT_W-1:0] class_count_q;
	logic [CORNER_W-1:0]      pad_x_q;
	logic [CORNER_W-1:0]      pad_y_q;
	logic [SCALE_W-1:0]       inv_scale_q;
	logic [SIZE_W-1:0]        img_w_q;
	logic [SIZE_W-1:0]        img_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			multi_q       <= 1'b1;
			thresh_q      <= THRESH_W'(16384);
			class_count_q <= CLASS_COUNT_W'(80);
			pad_x_q       <= '0;
			pad_y_q       <= '0;
			inv_scale_q   <= SCALE_W'(65536);
			img_w_q       <= SIZE_W'(640);
			img_h_q       <= SIZE_W'(640);
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_LABEL_MODE:  multi_q       <= cfg_data[0];
				CFG_THRESHOLD:   thresh_q      <= cfg_data[THRESH_W-1:0];
				CFG_CLASS_COUNT: class_count_q <= cfg_data[CLASS_COUNT_W-1:0];
				CFG_PAD_X:       pad_x_q       <= cfg_data[CORNER_W-1:0];
				CFG_PAD_Y:       pad_y_q       <= cfg_data[CORNER_W-1:0];
				CFG_INV_SCALE:   inv_scale_q   <= cfg_data[SCALE_W-1:0];
				CFG_IMG_WIDTH:   img_w_q       <= cfg_data[SIZE_W-1:0];
				CFG_IMG_HEIGHT:  img_h_q       <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// stage enables
	logic valid_s1, valid_s2, valid_s3;
	logic en1, en2, en3, en4, accept;

	assign en4 = !box_valid || box_ready;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign item_ready = en1;
	assign accept = item_valid && item_ready;

	// row state
	logic [POS_W-1:0] pos_q;
	logic [ROW_W-1:0] row_q;
	value_t           cx_q, cy_q, w_q, h_q, obj_q, best_q;
	logic [IDX_W-1:0] best_cls_q;

	logic [POS_W-1:0]   idx_full;
	logic [IDX_W-1:0]   idx;
	logic               in_box;
	logic [CMP_W-1:0]   cc_wide;
	logic [CNT_W-1:0]   cc_eff;
	logic               last;
	logic               take_best;
	value_t             best_new;
	logic [IDX_W-1:0]   best_cls_new;
	logic               cand;
	value_t             mul_sel;
	logic [IDX_W-1:0]   cls_sel;
	logic [IDX_W+CLASS_ID_W-1:0] cls_ext;

	always_comb begin
		in_box   = pos_q < POS_W'(BOX_FIELDS);
		idx_full = pos_q - POS_W'(BOX_FIELDS);
		idx      = idx_full[IDX_W-1:0];
		cc_wide  = CMP_W'(class_count_q);
		if (cc_wide == '0)
			cc_eff = CNT_W'(1);
		else if (cc_wide > CMP_W'(MAX_CLASSES))
			cc_eff = CNT_W'(MAX_CLASSES);
		else
			cc_eff = cc_wide[CNT_W-1:0];
		last = ({1'b0, CNT_W'(idx)} + (CNT_W+1)'(1)) >= {1'b0, cc_eff};
		take_best    = (idx == '0) || (value > best_q);
		best_new     = take_best ? value : best_q;
		best_cls_new = take_best ? idx : best_cls_q;
		cand    = !in_box && (multi_q || last);
		mul_sel = multi_q ? value : best_new;
		cls_sel = multi_q ? idx : best_cls_new;
		cls_ext = (IDX_W+CLASS_ID_W)'(cls_sel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (in_box) begin
				pos_q <= pos_q + POS_W'(1);
			end else if (last) begin
				pos_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (pos_q == POS_W'(FIELD_CX))
				cx_q <= value;
			if (pos_q == POS_W'(FIELD_CY))
				cy_q <= value;
			if (pos_q == POS_W'(FIELD_W))
				w_q <= value;
			if (pos_q == POS_W'(FIELD_H))
				h_q <= value;
			if (pos_q == POS_W'(FIELD_OBJ))
				obj_q <= value;
			if (!in_box) begin
				best_q     <= best_new;
				best_cls_q <= best_cls_new;
			end
		end
	end

	// stage 1: candidate beat
	value_t                 obj_s1, mul_s1, cx_s1, cy_s1, w_s1, h_s1;
	logic [CLASS_ID_W-1:0]  cls_s1;
	logic [ROW_W-1:0]       row_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en1)
			valid_s1 <= accept && cand;
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			obj_s1 <= obj_q;
			mul_s1 <= mul_sel;
			cls_s1 <= cls_ext[CLASS_ID_W-1:0];
			row_s1 <= row_q;
			cx_s1  <= cx_q;
			cy_s1  <= cy_q;
			w_s1   <= w_q;
			h_s1   <= h_q;
		end
	end

	// stage 2: confidence and corner distances
	logic signed [PROD_W-1:0] prod;
	logic signed [CONF_W-1:0] conf;
	logic                     pass;
	logic [SCORE_W-1:0]       conf_sat;
	logic signed [SPAN_W-1:0] span [CORNERS];
	logic signed [SPAN_W-1:0] half_w, half_h, ext_cx, ext_cy, ext_px, ext_py;

	always_comb begin
		prod = obj_s1 * mul_s1;
		conf = prod[PROD_W-1:FRAC_BITS];
		pass = conf > $signed({{(CONF_W-THRESH_W){1'b0}}, thresh_q});
		if (conf > $signed({{(CONF_W-SCORE_W){1'b0}}, SCORE_MAX}))
			conf_sat = SCORE_MAX;
		else
			conf_sat = conf[SCORE_W-1:0];
		half_w = SPAN_W'(w_s1 >>> 1);
		half_h = SPAN_W'(h_s1 >>> 1);
		ext_cx = SPAN_W'(cx_s1);
		ext_cy = SPAN_W'(cy_s1);
		ext_px = $signed({{(SPAN_W-CORNER_W){1'b0}}, pad_x_q});
		ext_py = $signed({{(SPAN_W-CORNER_W){1'b0}}, pad_y_q});
		span[C_LEFT]   = ext_cx - half_w - ext_px;
		span[C_TOP]    = ext_cy - half_h - ext_py;
		span[C_RIGHT]  = ext_cx + half_w - ext_px;
		span[C_BOTTOM] = ext_cy + half_h - ext_py;
	end

	logic signed [SPAN_W-1:0] span_s2 [CORNERS];
	logic [SCORE_W-1:0]       score_s2;
	logic [CLASS_ID_W-1:0]    cls_s2;
	logic [ROW_W-1:0]         row_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (en2)
			valid_s2 <= valid_s1 && pass;
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			span_s2  <= span;
			score_s2 <= conf_sat;
			cls_s2   <= cls_s1;
			row_s2   <= row_s1;
		end
	end

	// stage 3: partial products of distance by inverse scale
	logic signed [SCALE_W:0]  scale_ext;
	logic [PL_W-1:0]          pl [CORNERS];
	logic signed [PH_W-1:0]   ph [CORNERS];
	logic signed [HI_W-1:0]   span_hi;

	always_comb begin
		scale_ext = $signed({1'b0, inv_scale_q});
		for (int c = 0; c < CORNERS; c++) begin
			span_hi = span_s2[c][SPAN_W-1:LO_W];
			pl[c] = PL_W'(span_s2[c][LO_W-1:0]) * PL_W'(inv_scale_q);
			ph[c] = PH_W'(span_hi) * PH_W'(scale_ext);
		end
	end

	logic [PL_W-1:0]        pl_s3 [CORNERS];
	logic signed [PH_W-1:0] ph_s3 [CORNERS];
	logic [SCORE_W-1:0]     score_s3;
	logic [CLASS_ID_W-1:0]  cls_s3;
	logic [ROW_W-1:0]       row_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (en3)
			valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			pl_s3    <= pl;
			ph_s3    <= ph;
			score_s3 <= score_s2;
			cls_s3   <= cls_s2;
			row_s3   <= row_s2;
		end
	end

	// stage 4: sum, floor shift and clamp
	logic signed [SUM_W-1:0] total;
	logic signed [SHF_W-1:0] scaled;
	logic [CORNER_W-1:0]     bound;
	corner_t                 clamped [CORNERS];

	always_comb begin
		for (int c = 0; c < CORNERS; c++) begin
			total = $signed({ph_s3[c], {LO_W{1'b0}}})
				+ $signed({{(SUM_W-PL_W){1'b0}}, pl_s3[c]});
			scaled = total[SUM_W-1:FRAC_BITS];
			if (c == C_LEFT || c == C_RIGHT)
				bound = {img_w_q, {FRAC_BITS{1'b0}}};
			else
				bound = {img_h_q, {FRAC_BITS{1'b0}}};
			if (scaled < 0)
				clamped[c] = '0;
			else if (scaled > $signed({{(SHF_W-CORNER_W){1'b0}}, bound}))
				clamped[c] = bound;
			else
				clamped[c] = scaled[CORNER_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			box_valid <= 1'b0;
		else if (en4)
			box_valid <= valid_s3;
	end

	always_ff @(posedge clk) begin
		if (en4 && valid_s3) begin
			left      <= clamped[C_LEFT];
			top       <= clamped[C_TOP];
			right     <= clamped[C_RIGHT];
			bottom    <= clamped[C_BOTTOM];
			score     <= score_s3;
			class_id  <= cls_s3;
			row_index <= row_s3;
		end
	end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the detection box decode and filter block.
// ----------------------------------------------------------------------------
// Streams detector rows through the block under a series of register
// settings. A tracker keeps its own copy of the row state and registers,
// predicts every box on the input beat that causes it, and matches the boxes
// that come out in order, field by field. A short directed run covers the
// value extremes, saturation, ties and mid-row register changes. Random
// phases follow, each with fresh settings and, in all but the last, randomly chosen bursty idling on both sides.
// ----------------------------------------------------------------------------
module tb;
	import dbdf_pkg::*;

	localparam int MAX_CLASSES = 128;
	localparam int ITEMS_PER_PHASE = 190;
	localparam int SETTLE_CYCLES = 8;

	typedef struct {
		corner_t               left;
		corner_t               top;
		corner_t               right;
		corner_t               bottom;
		logic [SCORE_W-1:0]    score;
		logic [CLASS_ID_W-1:0] class_id;
		logic [ROW_W-1:0]      row_index;
	} box_t;

	class box_tracker;
		bit                     all_classes;
		bit [THRESH_W-1:0]      threshold;
		bit [CLASS_COUNT_W-1:0] class_count;
		bit [CORNER_W-1:0]      pad_x;
		bit [CORNER_W-1:0]      pad_y;
		bit [SCALE_W-1:0]       inv_scale;
		bit [SIZE_W-1:0]        img_w;
		bit [SIZE_W-1:0]        img_h;

		int unsigned  position;
		longint       centre_x;
		longint       centre_y;
		longint       box_w;
		longint       box_h;
		longint       objectness;
		longint       best_score;
		int unsigned  best_class;
		bit [ROW_W-1:0] rows_done;

		box_t pending_boxes[$];
		int   mismatches;

		function new();
			all_classes = 1'b1;
			threshold   = THRESH_W'(16384);
			class_count = CLASS_COUNT_W'(80);
			pad_x       = '0;
			pad_y       = '0;
			inv_scale   = SCALE_W'(65536);
			img_w       = SIZE_W'(640);
			img_h       = SIZE_W'(640);
			position    = 0;
			centre_x    = 0;
			centre_y    = 0;
			box_w       = 0;
			box_h       = 0;
			objectness  = 0;
			best_score  = 0;
			best_class  = 0;
			rows_done   = '0;
			mismatches  = 0;
		endfunction

		task report(string msg);
			mismatches++;
			$display("%0t mismatch: %s", $time, msg);
		endtask

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_LABEL_MODE:  all_classes = data[0];
				CFG_THRESHOLD:   threshold   = data[THRESH_W-1:0];
				CFG_CLASS_COUNT: class_count = data[CLASS_COUNT_W-1:0];
				CFG_PAD_X:       pad_x       = data[CORNER_W-1:0];
				CFG_PAD_Y:       pad_y       = data[CORNER_W-1:0];
				CFG_INV_SCALE:   inv_scale   = data[SCALE_W-1:0];
				CFG_IMG_WIDTH:   img_w       = data[SIZE_W-1:0];
				CFG_IMG_HEIGHT:  img_h       = data[SIZE_W-1:0];
				default: ;
			endcase
		endfunction

		// Q16.16 product, low bits dropped (floor)
		function longint fix_mul(longint a, longint b);
			return (a * b) >>> FRAC_BITS;
		endfunction

		function corner_t place(longint c, bit [CORNER_W-1:0] pad, bit [SIZE_W-1:0] size);
			longint v;
			longint bound;
			v = fix_mul(c - longint'(pad), longint'(inv_scale));
			bound = longint'(size) << FRAC_BITS;
			if (v < 0)
				v = 0;
			if (v > bound)
				v = bound;
			return corner_t'(v);
		endfunction

		function void push_box(longint conf, int unsigned cls);
			box_t   b;
			longint hw;
			longint hh;
			hw = box_w >>> 1;
			hh = box_h >>> 1;
			b.left      = place(centre_x - hw, pad_x, img_w);
			b.top       = place(centre_y - hh, pad_y, img_h);
			b.right     = place(centre_x + hw, pad_x, img_w);
			b.bottom    = place(centre_y + hh, pad_y, img_h);
			b.score     = (conf > longint'(SCORE_MAX)) ? SCORE_MAX : conf[SCORE_W-1:0];
			b.class_id  = cls[CLASS_ID_W-1:0];
			b.row_index = rows_done;
			pending_boxes.insert(pending_boxes.size(), b);
		endfunction

		function void take_value(value_t v);
			longint      sv;
			longint      conf;
			int unsigned cc;
			int unsigned idx;
			sv = longint'(v);
			cc = 32'(class_count);
			if (cc == 0)
				cc = 1;
			if (cc > MAX_CLASSES)
				cc = MAX_CLASSES;
			if (position < BOX_FIELDS) begin
				case (position)
					FIELD_CX: centre_x   = sv;
					FIELD_CY: centre_y   = sv;
					FIELD_W:  box_w      = sv;
					FIELD_H:  box_h      = sv;
					default:  objectness = sv;
				endcase
				position++;
				return;
			end
			idx = position - BOX_FIELDS;
			if (idx == 0 || sv > best_score) begin
				best_score = sv;
				best_class = idx;
			end
			if (all_classes) begin
				conf = fix_mul(objectness, sv);
				if (conf > longint'(threshold))
					push_box(conf, idx);
			end
			if (idx + 1 >= cc) begin
				if (!all_classes) begin
					conf = fix_mul(objectness, best_score);
					if (conf > longint'(threshold))
						push_box(conf, best_class);
				end
				position = 0;
				rows_done++;
			end else begin
				position++;
			end
		endfunction

		task check_field(string name, longint got, longint want, box_t ref_box);
			if (got != want)
				report($sformatf("row %0d class %0d: %s is %0h, expected %0h",
					ref_box.row_index, ref_box.class_id, name, got, want));
		endtask

		task match_box(box_t got);
			box_t want;
			if (pending_boxes.size() == 0) begin
				report($sformatf("unpredicted box: row %0d class %0d",
					got.row_index, got.class_id));
				return;
			end
			want = pending_boxes.pop_front();
			check_field("left", got.left, want.left, want);
			check_field("top", got.top, want.top, want);
			check_field("right", got.right, want.right, want);
			check_field("bottom", got.bottom, want.bottom, want);
			check_field("score", got.score, want.score, want);
			check_field("class_id", got.class_id, want.class_id, want);
			check_field("row_index", got.row_index, want.row_index, want);
		endtask
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_write;
	logic [CFG_INDEX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;
	logic                    item_valid;
	logic                    item_ready;
	value_t                  value;
	logic                    box_valid;
	logic                    box_ready;
	corner_t                 left;
	corner_t                 top;
	corner_t                 right;
	corner_t                 bottom;
	logic [SCORE_W-1:0]      score;
	logic [CLASS_ID_W-1:0]   class_id;
	logic [ROW_W-1:0]        row_index;

	box_tracker sb = new();
	int         send_idle = 0;
	int         recv_idle = 0;
	bit         wild_row  = 1'b0;

	detection_box_decode_filter #(
		.MAX_CLASSES(MAX_CLASSES)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.value     (value),
		.box_valid (box_valid),
		.box_ready (box_ready),
		.left      (left),
		.top       (top),
		.right     (right),
		.bottom    (bottom),
		.score     (score),
		.class_id  (class_id),
		.row_index (row_index)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		box_t seen;
		if (arst_n) begin
			if (box_valid && box_ready) begin
				seen.left      = left;
				seen.top       = top;
				seen.right     = right;
				seen.bottom    = bottom;
				seen.score     = score;
				seen.class_id  = class_id;
				seen.row_index = row_index;
				sb.match_box(seen);
			end
			if (item_valid && item_ready)
				sb.take_value(value);
			if (cfg_write)
				sb.set_reg(cfg_index, cfg_data);
		end
	end

	// result side: stall in bursts
	initial begin
		box_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (recv_idle != 0 && $urandom_range(1, 100) <= recv_idle) begin
				box_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end
			box_ready <= 1'b1;
		end
	end

	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(data);
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// entered and left just after a falling edge
	task automatic send_value(input value_t v);
		if (send_idle != 0 && $urandom_range(1, 100) <= send_idle) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		item_valid <= 1'b1;
		value      <= v;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// hold input until every predicted box is out, then let the pipe empty
	task automatic settle();
		int waited;
		item_valid <= 1'b0;
		for (waited = 0; waited < 4000 && sb.pending_boxes.size() != 0; waited++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic value_t pick_value();
		if (sb.position == 0)
			wild_row = ($urandom_range(0, 3) == 0);
		if (wild_row && $urandom_range(0, 3) != 0)
			return $urandom;
		case (sb.position)
			FIELD_CX, FIELD_CY: return $urandom_range(0, 32'h0400_0000);
			FIELD_W, FIELD_H:   return $urandom_range(0, 32'h0200_0000);
			default:            return $urandom_range(0, 32'h0001_0000);
		endcase
	endfunction

	function automatic int unsigned pick_pad();
		case ($urandom_range(0, 5))
			0:       return 0;
			1:       return 32'h3FFF_FFFF;
			2:       return $urandom;
			default: return $urandom_range(0, 64 << FRAC_BITS);
		endcase
	endfunction

	function automatic int unsigned pick_size();
		case ($urandom_range(0, 7))
			0:       return 0;
			1:       return 1;
			2:       return 8192;
			3:       return 16383;
			default: return $urandom_range(100, 2000);
		endcase
	endfunction

	task automatic randomise_setup();
		int unsigned d;
		write_reg(CFG_LABEL_MODE, $urandom_range(0, 1));
		case ($urandom_range(0, 5))
			0:       d = 0;
			1:       d = 65536;
			2:       d = 131071;
			default: d = $urandom_range(0, 65536);
		endcase
		write_reg(CFG_THRESHOLD, d);
		case ($urandom_range(0, 11))
			0:       d = 0;
			1:       d = MAX_CLASSES;
			2:       d = $urandom_range(MAX_CLASSES + 1, 255);
			3, 4:    d = $urandom_range(9, 40);
			default: d = $urandom_range(1, 8);
		endcase
		write_reg(CFG_CLASS_COUNT, d);
		write_reg(CFG_PAD_X, pick_pad());
		write_reg(CFG_PAD_Y, pick_pad());
		case ($urandom_range(0, 7))
			0:       d = 0;
			1:       d = 1;
			2:       d = (1 << SCALE_W) - 1;
			3:       d = 1 << 20;
			default: d = $urandom_range(32768, 131072);
		endcase
		write_reg(CFG_INV_SCALE, d);
		write_reg(CFG_IMG_WIDTH, pick_size());
		write_reg(CFG_IMG_HEIGHT, pick_size());
	endtask

	function automatic int pick_idle();
		case ($urandom_range(0, 3))
			0:       return 0;
			1:       return 3;
			2:       return 12;
			default: return 40;
		endcase
	endfunction

	initial begin
		int phase;
		arst_n     = 1'b0;
		cfg_write  = 1'b0;
		cfg_index  = CFG_LABEL_MODE;
		cfg_data   = '0;
		item_valid = 1'b0;
		value      = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// extremes of every row value, saturated and negative confidence
		write_reg(CFG_LABEL_MODE, 1);
		write_reg(CFG_THRESHOLD, 0);
		write_reg(CFG_CLASS_COUNT, 2);
		write_reg(CFG_PAD_X, 0);
		write_reg(CFG_PAD_Y, 0);
		write_reg(CFG_INV_SCALE, 65536);
		write_reg(CFG_IMG_WIDTH, 640);
		write_reg(CFG_IMG_HEIGHT, 640);
		send_value(32'h7FFF_FFFF);
		send_value(32'h8000_0000);
		send_value(32'h7FFF_FFFF);
		send_value(32'h8000_0000);
		send_value(32'h7FFF_FFFF);
		send_value(32'h7FFF_FFFF);
		send_value(32'h8000_0000);
		send_value(100 << FRAC_BITS);
		send_value(50 << FRAC_BITS);
		send_value(-1);
		send_value(3);
		send_value(-65536);
		send_value(-65536);
		send_value(65536);
		settle();

		// best-class mode, zero class count, zero scale, widest pads, widest width and zero height
		write_reg(CFG_LABEL_MODE, 0);
		write_reg(CFG_THRESHOLD, 65536);
		write_reg(CFG_CLASS_COUNT, 0);
		write_reg(CFG_INV_SCALE, 0);
		write_reg(CFG_PAD_X, '1);
		write_reg(CFG_PAD_Y, '1);
		write_reg(CFG_IMG_WIDTH, '1);
		write_reg(CFG_IMG_HEIGHT, 0);
		send_value(10 << FRAC_BITS);
		send_value(20 << FRAC_BITS);
		send_value(4 << FRAC_BITS);
		send_value(6 << FRAC_BITS);
		send_value(2 << FRAC_BITS);
		send_value(65536);
		settle();

		// tie on the best score, then class count lowered mid-row
		write_reg(CFG_THRESHOLD, 49999);
		write_reg(CFG_CLASS_COUNT, 3);
		write_reg(CFG_INV_SCALE, 65536);
		write_reg(CFG_PAD_X, 5 << FRAC_BITS);
		write_reg(CFG_PAD_Y, 0);
		write_reg(CFG_IMG_WIDTH, 8192);
		write_reg(CFG_IMG_HEIGHT, 1);
		send_value(300 << FRAC_BITS);
		send_value(200 << FRAC_BITS);
		send_value(80 << FRAC_BITS);
		send_value(60 << FRAC_BITS);
		send_value(65536);
		send_value(50000);
		send_value(50000);
		settle();
		write_reg(CFG_CLASS_COUNT, 1);
		send_value(20000);
		settle();

		// random phases; phase ends often fall mid-row
		for (phase = 0; phase < 10; phase++) begin
			if (phase >= 9) begin
				send_idle = 0;
				recv_idle = 0;
			end else begin
				send_idle = pick_idle();
				recv_idle = pick_idle();
			end
			randomise_setup();
			repeat (ITEMS_PER_PHASE)
				send_value(pick_value());
			settle();
		end

		if (sb.pending_boxes.size() != 0)
			sb.report($sformatf("%0d predicted boxes never came", sb.pending_boxes.size()));
		if (sb.mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

>>> detection_box_decode_filter.f
hw/rtl/dbdf_pkg.sv
hw/rtl/detection_box_decode_filter.sv
dv/tb.sv
